FILE: hdl/nfdw_pkg.sv
// types and constants shared by the first-derivative weight block
// no dependencies
package nfdw_pkg;

  localparam int NPTS     = 5;    // stencil points
  localparam int NOTH     = 4;    // other points seen by one lane
  localparam int POS_W    = 32;   // signed Q12.20 position
  localparam int WT_W     = 48;   // signed Q24.24 weight
  localparam int NUM_W    = 96;   // numerator magnitude
  localparam int DEN_W    = 128;  // denominator magnitude
  localparam int QB       = 48;   // quotient bits per lane
  localparam int PRE_LAT  = 6;    // lane product stages
  localparam int DIV_LAT  = QB + 2;
  localparam int LANE_LAT = PRE_LAT + DIV_LAT;

  localparam logic [2:0] MAX_ORDER = 3'd4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_ORDER  = 2'd1,
    ST_COINCIDENT = 2'd2,
    ST_SATURATED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]              order;
    logic signed [POS_W-1:0] pos_a;
    logic signed [POS_W-1:0] pos_b;
    logic signed [POS_W-1:0] pos_c;
    logic signed [POS_W-1:0] pos_d;
    logic signed [POS_W-1:0] pos_e;
  } in_t;

  typedef struct packed {
    logic signed [WT_W-1:0] weight_a;
    logic signed [WT_W-1:0] weight_b;
    logic signed [WT_W-1:0] weight_c;
    logic signed [WT_W-1:0] weight_d;
    logic signed [WT_W-1:0] weight_e;
    logic [2:0]             weight_count;
    status_e                status;
  } out_t;

  // item flags that travel beside the lanes
  typedef struct packed {
    logic       bad;
    logic       coinc;
    logic [2:0] cnt;
  } meta_t;

  typedef struct packed {
    logic signed [WT_W-1:0] weight;
    logic                   sat;
  } lane_res_t;

endpackage

FILE: hdl/nonuniform_first_derivative_weights.sv
// top level of the first-derivative weight block: input register, five lanes, merge
// depends on nfdw_pkg, nfdw_lane, nfdw_div and nfdw_merge
//
// Takes an order (0 to 4) and five signed Q12.20 positions and returns the first-derivative
// finite-difference weights at position zero in signed Q24.24, one per used point, with a
// count and a status (bad order, coincident points, saturation; checked in that order).
// Each weight is computed exactly as a ratio of wide integer products, rounded to nearest
// with ties away from zero and clamped to 48 bits. Five lanes, one per weight, run side by
// side; each forms its numerator and denominator products from 32x32 multipliers over six
// stages and then feeds a 48-stage restoring divider that yields one quotient bit a stage.
// A merge stage gathers the lanes into the output register. A new transaction is taken
// every cycle while the pipeline is not stalled.
// The output register decouples the two sides, so input is still taken while a result
// waits unless the pipeline's last stage also holds one.
module nonuniform_first_derivative_weights
  import nfdw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [LANE_LAT:0] vld_q;       // stage 0 is the input register
  in_t               in_q;
  meta_t             meta_q [1:LANE_LAT];
  logic              out_valid_q;
  logic              en;          // whole pipeline advances
  logic              out_ld;      // output register free or being emptied

  assign out_ld     = out_ready_i | ~out_valid_q;
  assign en         = out_ld | ~vld_q[LANE_LAT];
  assign in_ready_o = en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LANE_LAT-1:0], in_valid_i};
      end
      if (out_ld) begin
        out_valid_q <= vld_q[LANE_LAT];
      end
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  // decode: point count, bad order, coincident points
  logic signed [POS_W-1:0] x [NPTS];
  meta_t                   meta_d;

  always_comb begin
    x[0] = in_q.pos_a;
    x[1] = in_q.pos_b;
    x[2] = in_q.pos_c;
    x[3] = in_q.pos_d;
    x[4] = in_q.pos_e;
    meta_d.bad   = in_q.order > MAX_ORDER;
    meta_d.cnt   = in_q.order + 3'd1;
    meta_d.coinc = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      for (int j = i + 1; j < NPTS; j++) begin
        if (3'(j) < meta_d.cnt && x[i] == x[j]) begin
          meta_d.coinc = ~meta_d.bad;
        end
      end
    end
  end

  // flags ride alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[1] <= meta_d;
      for (int k = 2; k <= LANE_LAT; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // lanes: lane i sees its own point and the other four in order
  lane_res_t lane_res [NPTS];

  for (genvar i = 0; i < NPTS; i++) begin : g_lane
    logic signed [POS_W-1:0] xo  [NOTH];
    logic [NOTH-1:0]         act;

    always_comb begin
      for (int s = 0; s < NOTH; s++) begin
        if (s < i) begin
          xo[s]  = x[s];
          act[s] = 3'(s) < meta_d.cnt;
        end else begin
          xo[s]  = x[s+1];
          act[s] = 3'(s + 1) < meta_d.cnt;
        end
      end
    end

    nfdw_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .xi_i  (x[i]),
      .xo_i  (xo),
      .act_i (act),
      .res_o (lane_res[i])
    );
  end

  nfdw_merge u_merge (
    .clk_i  (clk_i),
    .ld_i   (out_ld),
    .meta_i (meta_q[LANE_LAT]),
    .res_i  (lane_res),
    .out_o  (out_data_o)
  );

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // bad order carries no weights
  a_bad_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_BAD_ORDER) |->
      (out_data_o.weight_count == 3'd0 && out_data_o.weight_a == '0))
    else $error("bad order transaction with weights");

  // zero or one point gives all-zero weights
  a_trivial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.weight_count <= 3'd1) |->
      (out_data_o.weight_a == '0 && out_data_o.weight_b == '0 &&
       out_data_o.weight_c == '0 && out_data_o.weight_d == '0 &&
       out_data_o.weight_e == '0))
    else $error("nonzero weight on trivial stencil");

  // saturation only with a real stencil
  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_SATURATED) |->
      (out_data_o.weight_count >= 3'd2))
    else $error("saturation flagged without weights");
`endif

endmodule

FILE: hdl/nfdw_div.sv
// pipelined restoring divider with rounding and saturation, one quotient bit a stage
// depends on nfdw_pkg
module nfdw_div
  import nfdw_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             neg_i,
  output lane_res_t        res_o
);

  logic [DEN_W-1:0] r_q    [QB+1];
  logic [DEN_W-1:0] den_q  [QB+1];
  logic [QB-1:0]    q_q    [QB+1];
  logic [QB-1:0]    bits_q [QB+1];
  logic [QB:0]      ovf_q;
  logic [QB:0]      neg_q;
  lane_res_t        res_q;

  // initial partial remainder is num * 2^44 / 2^48
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= {{(DEN_W-NUM_W+4){1'b0}}, num_i[NUM_W-1:4]};
      ovf_q[0]  <= {{(DEN_W-NUM_W+4){1'b0}}, num_i[NUM_W-1:4]} >= den_i;
      bits_q[0] <= {num_i[3:0], {(QB-4){1'b0}}};
      q_q[0]    <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= neg_i;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {r_q[k-1], bits_q[k-1][QB-1]};
    assign ge = t >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? DEN_W'(t - {1'b0, den_q[k-1]}) : t[DEN_W-1:0];
        q_q[k]    <= {q_q[k-1][QB-2:0], ge};
        bits_q[k] <= {bits_q[k-1][QB-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
  end

  logic          rnd;
  logic [QB:0]   qr;
  logic [QB:0]   lim;
  logic          sat;
  logic [QB:0]   qv;
  lane_res_t     res_d;

  always_comb begin
    rnd   = {r_q[QB], 1'b0} >= {1'b0, den_q[QB]};
    qr    = {1'b0, q_q[QB]} + {{QB{1'b0}}, rnd};
    lim   = neg_q[QB] ? ((QB+1)'(1) << (WT_W-1)) : (((QB+1)'(1) << (WT_W-1)) - (QB+1)'(1));
    sat   = ovf_q[QB] | (qr > lim);
    qv    = sat ? lim : qr;
    res_d.sat    = sat;
    res_d.weight = neg_q[QB] ? -qv[WT_W-1:0] : qv[WT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: hdl/nfdw_lane.sv
// one weight lane: numerator and denominator products, then the divider
// depends on nfdw_pkg and nfdw_div
module nfdw_lane
  import nfdw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [POS_W-1:0] xi_i,
  input  logic signed [POS_W-1:0] xo_i [NOTH],
  input  logic [NOTH-1:0]         act_i,
  output lane_res_t               res_o
);

  // stage 1: magnitudes and signs of -x_j and x_i - x_j
  logic [31:0]     ym_d [NOTH];
  logic [31:0]     dm_d [NOTH];
  logic [NOTH-1:0] ys_d, ds_d;
  logic [32:0]     dd;
  logic [31:0]     ym_q [NOTH];
  logic [31:0]     dm_q [NOTH];
  logic [NOTH-1:0] ys_q, ds_q, act1_q;

  always_comb begin
    dd = '0;
    for (int s = 0; s < NOTH; s++) begin
      dd = {xi_i[POS_W-1], xi_i} - {xo_i[s][POS_W-1], xo_i[s]};
      if (act_i[s]) begin
        ym_d[s] = xo_i[s][POS_W-1] ? (~xo_i[s] + 32'd1) : xo_i[s];
        ys_d[s] = ~xo_i[s][POS_W-1] & (xo_i[s] != '0);
        dm_d[s] = dd[32] ? 32'(~dd + 33'd1) : dd[31:0];
        ds_d[s] = dd[32];
      end else begin
        ym_d[s] = 32'd1;
        ys_d[s] = 1'b0;
        dm_d[s] = 32'd1;
        ds_d[s] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ym_q   <= ym_d;
      dm_q   <= dm_d;
      ys_q   <= ys_d;
      ds_q   <= ds_d;
      act1_q <= act_i;
    end
  end

  // stage 2: pair products
  logic [63:0]     yp01_q, yp23_q, dp01_q, dp23_q;
  logic            yps01_q, yps23_q, dsg2_q;
  logic [31:0]     ym2_q [NOTH];
  logic [NOTH-1:0] ys2_q, act2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yp01_q  <= ym_q[0] * ym_q[1];
      yp23_q  <= ym_q[2] * ym_q[3];
      dp01_q  <= dm_q[0] * dm_q[1];
      dp23_q  <= dm_q[2] * dm_q[3];
      yps01_q <= ys_q[0] ^ ys_q[1];
      yps23_q <= ys_q[2] ^ ys_q[3];
      dsg2_q  <= ^ds_q;
      ym2_q   <= ym_q;
      ys2_q   <= ys_q;
      act2_q  <= act1_q;
    end
  end

  // stage 3: partial products of the leave-one-out terms and of the denominator
  logic [31:0]     sgl  [NOTH];
  logic [63:0]     pr   [NOTH];
  logic [NOTH-1:0] lsg;
  logic [63:0]     llo_q [NOTH];
  logic [63:0]     lhi_q [NOTH];
  logic [NOTH-1:0] lsg_q, act3_q;
  logic [63:0]     d00_q, d01_q, d10_q, d11_q;
  logic            dsg3_q;

  always_comb begin
    sgl[0] = ym2_q[1]; pr[0] = yp23_q; lsg[0] = ys2_q[1] ^ yps23_q;
    sgl[1] = ym2_q[0]; pr[1] = yp23_q; lsg[1] = ys2_q[0] ^ yps23_q;
    sgl[2] = ym2_q[3]; pr[2] = yp01_q; lsg[2] = ys2_q[3] ^ yps01_q;
    sgl[3] = ym2_q[2]; pr[3] = yp01_q; lsg[3] = ys2_q[2] ^ yps01_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NOTH; s++) begin
        llo_q[s] <= sgl[s] * pr[s][31:0];
        lhi_q[s] <= sgl[s] * pr[s][63:32];
      end
      lsg_q  <= lsg;
      act3_q <= act2_q;
      d00_q  <= dp01_q[31:0] * dp23_q[31:0];
      d01_q  <= dp01_q[31:0] * dp23_q[63:32];
      d10_q  <= dp01_q[63:32] * dp23_q[31:0];
      d11_q  <= dp01_q[63:32] * dp23_q[63:32];
      dsg3_q <= dsg2_q;
    end
  end

  // stage 4: assemble full products
  logic [NUM_W-1:0] lm_q [NOTH];
  logic [NOTH-1:0]  lsg4_q, act4_q;
  logic [DEN_W-1:0] den4_q;
  logic             dsg4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NOTH; s++) begin
        lm_q[s] <= {32'd0, llo_q[s]} + {lhi_q[s], 32'd0};
      end
      lsg4_q <= lsg_q;
      act4_q <= act3_q;
      den4_q <= {64'd0, d00_q} + {32'd0, d01_q, 32'd0} + {32'd0, d10_q, 32'd0}
                + {d11_q, 64'd0};
      dsg4_q <= dsg3_q;
    end
  end

  // stage 5: signed numerator sum over the active points
  logic [NUM_W+1:0] nsum_d;
  logic [NUM_W+1:0] nsum_q;
  logic [DEN_W-1:0] den5_q;
  logic             dsg5_q;

  always_comb begin
    nsum_d = '0;
    for (int s = 0; s < NOTH; s++) begin
      if (act4_q[s]) begin
        nsum_d = nsum_d + (lsg4_q[s] ? -{2'b00, lm_q[s]} : {2'b00, lm_q[s]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nsum_q <= nsum_d;
      den5_q <= den4_q;
      dsg5_q <= dsg4_q;
    end
  end

  // stage 6: magnitude and result sign
  logic [NUM_W+1:0] nabs;
  logic [NUM_W-1:0] nmag_q;
  logic [DEN_W-1:0] den6_q;
  logic             neg6_q;

  assign nabs = nsum_q[NUM_W+1] ? (~nsum_q + 1'b1) : nsum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q <= nabs[NUM_W-1:0];
      den6_q <= den5_q;
      neg6_q <= nsum_q[NUM_W+1] ^ dsg5_q;
    end
  end

  nfdw_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (nmag_q),
    .den_i (den6_q),
    .neg_i (neg6_q),
    .res_o (res_o)
  );

endmodule

FILE: hdl/nfdw_merge.sv
// merge stage: gathers the lane weights and flags into the output register
// depends on nfdw_pkg
module nfdw_merge
  import nfdw_pkg::*;
(
  input  logic      clk_i,
  input  logic      ld_i,
  input  meta_t     meta_i,
  input  lane_res_t res_i [NPTS],
  output out_t      out_o
);

  logic signed [WT_W-1:0] w [NPTS];
  logic                   ok;
  logic                   sat;
  out_t                   out_d;
  out_t                   out_q;

  always_comb begin
    ok  = ~meta_i.bad & ~meta_i.coinc;
    sat = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      if (ok && meta_i.cnt > 3'd1 && 3'(i) < meta_i.cnt) begin
        w[i] = res_i[i].weight;
        sat  = sat | res_i[i].sat;
      end else begin
        w[i] = '0;
      end
    end
    out_d.weight_a     = w[0];
    out_d.weight_b     = w[1];
    out_d.weight_c     = w[2];
    out_d.weight_d     = w[3];
    out_d.weight_e     = w[4];
    out_d.weight_count = ok ? meta_i.cnt : 3'd0;
    if (meta_i.bad) begin
      out_d.status = ST_BAD_ORDER;
    end else if (meta_i.coinc) begin
      out_d.status = ST_COINCIDENT;
    end else if (sat) begin
      out_d.status = ST_SATURATED;
    end else begin
      out_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule
